FILE: rtl/zero_cross_synced_rms_meter_assert.svh
// assertion macros used by the rms meter back end
`ifndef ZERO_CROSS_SYNCED_RMS_METER_ASSERT_SVH
`define ZERO_CROSS_SYNCED_RMS_METER_ASSERT_SVH
// condition must hold on every edge out of reset
`define ZC_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// consequence in the same cycle
`define ZC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// consequence in the next cycle
`define ZC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/zcsrm_pkg.sv
// shared types and constants of the rms meter
package zcsrm_pkg;

  typedef enum logic [1:0] {PH_IDLE, PH_SYNC, PH_MEAS} phase_e;

  typedef enum logic [2:0] {BK_IDLE, BK_DIV, BK_SQRT, BK_MUL, BK_RND, BK_OUT} bstate_e;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam int CFG_W  = 10;
  localparam int TIME_W = 16;
  localparam int GAIN_W = 24;
  localparam int RMS_W  = 25;
  localparam int USED_W = 16;
  localparam int IDX_W  = 3;
  localparam int DATA_W = 24;
  localparam int FRAC_SHIFT = 8;

  localparam logic [IDX_W-1:0] REG_OFFSET_V    = 3'd0;
  localparam logic [IDX_W-1:0] REG_OFFSET_I    = 3'd1;
  localparam logic [IDX_W-1:0] REG_WINDOW_LOW  = 3'd2;
  localparam logic [IDX_W-1:0] REG_WINDOW_HIGH = 3'd3;
  localparam logic [IDX_W-1:0] REG_CROSS_TGT   = 3'd4;
  localparam logic [IDX_W-1:0] REG_TIMEOUT     = 3'd5;
  localparam logic [IDX_W-1:0] REG_GAIN_V      = 3'd6;
  localparam logic [IDX_W-1:0] REG_GAIN_I      = 3'd7;

  typedef struct packed {
    logic [CFG_W-1:0]  offset_v;
    logic [CFG_W-1:0]  offset_i;
    logic [CFG_W-1:0]  window_low;
    logic [CFG_W-1:0]  window_high;
    logic [CFG_W-1:0]  crossing_target;
    logic [TIME_W-1:0] timeout_ms;
    logic [GAIN_W-1:0] gain_v;
    logic [GAIN_W-1:0] gain_i;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    offset_v:        10'd512,
    offset_i:        10'd512,
    window_low:      10'd461,
    window_high:     10'd564,
    crossing_target: 10'd20,
    timeout_ms:      16'd2000,
    gain_v:          24'd81600,
    gain_i:          24'd12118
  };

endpackage

FILE: rtl/zero_cross_synced_rms_meter.sv
// top level of the zero-cross synchronized true rms meter
// The front end takes one request per clock while in_stall_o is low: start,
// sample pair or 1 ms tick. It runs the sync / measure phases, squares and
// accumulates offset-removed samples and counts mid-level crossings, all in
// the accepting cycle. When a measurement ends, its sums, pair count and
// timeout flag go into a two-entry queue. The back end turns each entry into
// a result: a restoring divider forms the mean as a SUM_W-bit quotient
// (SUM_W = 2*SAMPLE_BITS+COUNT_BITS-2, 34 at defaults), a digit recurrence
// takes the root, then the root is multiplied by the gain and rounded.
// Input stall rises only when two finished measurements still wait in the
// queue. The result sits in an output register until taken. Config writes
// apply on the edge where cfg_we_i is high.
module zero_cross_synced_rms_meter #(
  parameter int SAMPLE_BITS = 10,
  parameter int COUNT_BITS  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [zcsrm_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [zcsrm_pkg::DATA_W-1:0]    cfg_data_i,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      op_i,
  input  logic [SAMPLE_BITS-1:0]          v_sample_i,
  input  logic [SAMPLE_BITS-1:0]          i_sample_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [zcsrm_pkg::RMS_W-1:0]     v_rms_o,
  output logic [zcsrm_pkg::RMS_W-1:0]     i_rms_o,
  output logic [zcsrm_pkg::USED_W-1:0]    samples_used_o,
  output logic                            timed_out_o
);

  // accumulator width: sums of squares of offset-removed samples, saturating at the top
  localparam int SUM_W   = 2 * SAMPLE_BITS + COUNT_BITS - 2;
  localparam int ENTRY_W = 2 * SUM_W + COUNT_BITS + 1;

  zcsrm_pkg::cfg_t        cfg_q;
  logic                   push_valid, full, pop, pop_valid;
  logic [ENTRY_W-1:0]     push_data, pop_data;

  // config registers, low bits of the write data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= zcsrm_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        zcsrm_pkg::REG_OFFSET_V:    cfg_q.offset_v        <= cfg_data_i[zcsrm_pkg::CFG_W-1:0];
        zcsrm_pkg::REG_OFFSET_I:    cfg_q.offset_i        <= cfg_data_i[zcsrm_pkg::CFG_W-1:0];
        zcsrm_pkg::REG_WINDOW_LOW:  cfg_q.window_low      <= cfg_data_i[zcsrm_pkg::CFG_W-1:0];
        zcsrm_pkg::REG_WINDOW_HIGH: cfg_q.window_high     <= cfg_data_i[zcsrm_pkg::CFG_W-1:0];
        zcsrm_pkg::REG_CROSS_TGT:   cfg_q.crossing_target <= cfg_data_i[zcsrm_pkg::CFG_W-1:0];
        zcsrm_pkg::REG_TIMEOUT:     cfg_q.timeout_ms      <= cfg_data_i[zcsrm_pkg::TIME_W-1:0];
        zcsrm_pkg::REG_GAIN_V:      cfg_q.gain_v          <= cfg_data_i[zcsrm_pkg::GAIN_W-1:0];
        zcsrm_pkg::REG_GAIN_I:      cfg_q.gain_i          <= cfg_data_i[zcsrm_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // phase control and accumulation
  zcsrm_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS),
    .SUM_W      (SUM_W),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .v_sample_i  (v_sample_i),
    .i_sample_i  (i_sample_i),
    .push_valid_o(push_valid),
    .push_data_o (push_data),
    .push_full_i (full)
  );

  // finished measurements waiting for the back end
  zcsrm_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(2)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_valid),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .pop_valid_o(pop_valid),
    .pop_data_o (pop_data)
  );

  // mean, root, gain and output register
  zcsrm_back #(
    .COUNT_BITS(COUNT_BITS),
    .SUM_W     (SUM_W),
    .ENTRY_W   (ENTRY_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .pop_valid_i   (pop_valid),
    .pop_data_i    (pop_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .v_rms_o       (v_rms_o),
    .i_rms_o       (i_rms_o),
    .samples_used_o(samples_used_o),
    .timed_out_o   (timed_out_o)
  );

endmodule

FILE: rtl/zcsrm_front.sv
// front end: phase control, squaring accumulators and end detection
module zcsrm_front #(
  parameter int SAMPLE_BITS = 10,
  parameter int COUNT_BITS  = 16,
  parameter int SUM_W       = 2 * SAMPLE_BITS + COUNT_BITS - 2,
  parameter int ENTRY_W     = 2 * SUM_W + COUNT_BITS + 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  zcsrm_pkg::cfg_t        cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             op_i,
  input  logic [SAMPLE_BITS-1:0] v_sample_i,
  input  logic [SAMPLE_BITS-1:0] i_sample_i,
  output logic                   push_valid_o,
  output logic [ENTRY_W-1:0]     push_data_o,
  input  logic                   push_full_i
);

  localparam int DW    = ((SAMPLE_BITS > zcsrm_pkg::CFG_W) ? SAMPLE_BITS : zcsrm_pkg::CFG_W) + 1;
  localparam int SQ_W  = 2 * DW;
  localparam int ADD_W = ((SUM_W > SQ_W) ? SUM_W : SQ_W) + 1;
  localparam logic [SUM_W-1:0]      SUM_MAX   = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [zcsrm_pkg::TIME_W-1:0] TIME_MAX = '1;

  zcsrm_pkg::phase_e              phase_q, phase_d;
  logic [zcsrm_pkg::TIME_W-1:0]   elapsed_q, elapsed_d;
  logic [SAMPLE_BITS-1:0]         mid_q, mid_d;
  logic [COUNT_BITS-1:0]          pair_q, pair_d;
  logic [zcsrm_pkg::CFG_W-1:0]    cross_q, cross_d;
  logic                           above_q, above_d;
  logic [SUM_W-1:0]               sumv_q, sumv_d, sumi_q, sumi_d;

  logic                           accept, enter, check, push, timed, above;
  logic signed [DW-1:0]           dv, di;
  logic [DW-1:0]                  av, ai;
  logic [SQ_W-1:0]                sqv, sqi;
  logic [ADD_W-1:0]               addv, addi;

  assign in_stall_o = push_full_i;
  assign accept     = in_valid_i && !push_full_i;

  always_comb begin
    dv   = $signed(DW'(v_sample_i)) - $signed(DW'(cfg_i.offset_v));
    di   = $signed(DW'(i_sample_i)) - $signed(DW'(cfg_i.offset_i));
    av   = dv[DW-1] ? DW'(-dv) : DW'(dv);
    ai   = di[DW-1] ? DW'(-di) : DW'(di);
    sqv  = SQ_W'(av) * SQ_W'(av);
    sqi  = SQ_W'(ai) * SQ_W'(ai);
    addv = ADD_W'(sumv_q) + ADD_W'(sqv);
    addi = ADD_W'(sumi_q) + ADD_W'(sqi);
    above = v_sample_i > mid_q;

    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    mid_d     = mid_q;
    pair_d    = pair_q;
    cross_d   = cross_q;
    above_d   = above_q;
    sumv_d    = sumv_q;
    sumi_d    = sumi_q;
    enter = 1'b0;
    check = 1'b0;
    push  = 1'b0;
    timed = 1'b0;

    if (accept) begin
      case (op_i)
        zcsrm_pkg::OP_START: begin
          phase_d   = zcsrm_pkg::PH_SYNC;
          elapsed_d = '0;
        end
        zcsrm_pkg::OP_SAMPLE: begin
          if (phase_q == zcsrm_pkg::PH_SYNC) begin
            mid_d = v_sample_i;
            if (v_sample_i > cfg_i.window_low && v_sample_i < cfg_i.window_high) enter = 1'b1;
          end else if (phase_q == zcsrm_pkg::PH_MEAS) begin
            pair_d = pair_q + 1'b1;
            sumv_d = (addv > ADD_W'(SUM_MAX)) ? SUM_MAX : addv[SUM_W-1:0];
            sumi_d = (addi > ADD_W'(SUM_MAX)) ? SUM_MAX : addi[SUM_W-1:0];
            if (pair_q != '0 && above != above_q) cross_d = cross_q + 1'b1;
            above_d = above;
            check   = 1'b1;
          end
        end
        zcsrm_pkg::OP_TICK: begin
          if (phase_q == zcsrm_pkg::PH_SYNC) begin
            if (elapsed_q >= cfg_i.timeout_ms) enter = 1'b1;
            else elapsed_d = elapsed_q + 1'b1;
          end else if (phase_q == zcsrm_pkg::PH_MEAS) begin
            if (elapsed_q != TIME_MAX) elapsed_d = elapsed_q + 1'b1;
            check = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (enter) begin
      phase_d   = zcsrm_pkg::PH_MEAS;
      elapsed_d = '0;
      pair_d    = '0;
      cross_d   = '0;
      above_d   = 1'b0;
      sumv_d    = '0;
      sumi_d    = '0;
      check     = 1'b1;
    end

    if (check) begin
      if (cross_d >= cfg_i.crossing_target) begin
        push = 1'b1;
      end else if (pair_d == COUNT_MAX) begin
        push = 1'b1;
      end else if (elapsed_d >= cfg_i.timeout_ms) begin
        push  = 1'b1;
        timed = 1'b1;
      end
    end
    if (push) phase_d = zcsrm_pkg::PH_IDLE;
  end

  assign push_valid_o = push;
  assign push_data_o  = {timed, pair_d, sumi_d, sumv_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= zcsrm_pkg::PH_IDLE;
      elapsed_q <= '0;
      mid_q     <= '0;
      pair_q    <= '0;
      cross_q   <= '0;
      above_q   <= 1'b0;
      sumv_q    <= '0;
      sumi_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      mid_q     <= mid_d;
      pair_q    <= pair_d;
      cross_q   <= cross_d;
      above_q   <= above_d;
      sumv_q    <= sumv_d;
      sumi_q    <= sumi_d;
    end
  end

endmodule

FILE: rtl/zcsrm_fifo.sv
// short queue of finished measurements between front and back
module zcsrm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             pop_valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [PW:0]      cnt_q;

  assign full_o      = cnt_q == (PW+1)'(DEPTH);
  assign pop_valid_o = cnt_q != '0;
  assign pop_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

FILE: rtl/zcsrm_back.sv
// back end: mean by restoring divide, root by digit recurrence, gain and rounding
`include "zero_cross_synced_rms_meter_assert.svh"
module zcsrm_back #(
  parameter int COUNT_BITS = 16,
  parameter int SUM_W      = 36,
  parameter int ENTRY_W    = 2 * SUM_W + COUNT_BITS + 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  zcsrm_pkg::cfg_t                 cfg_i,
  input  logic                            pop_valid_i,
  input  logic [ENTRY_W-1:0]              pop_data_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [zcsrm_pkg::RMS_W-1:0]     v_rms_o,
  output logic [zcsrm_pkg::RMS_W-1:0]     i_rms_o,
  output logic [zcsrm_pkg::USED_W-1:0]    samples_used_o,
  output logic                            timed_out_o
);

  localparam int RW    = (SUM_W + 1) / 2;
  localparam int X_W   = 2 * RW;
  localparam int CW    = $clog2(SUM_W);
  localparam int P_W   = RW + zcsrm_pkg::GAIN_W;
  localparam int RND_W = P_W + 1;
  localparam logic [zcsrm_pkg::RMS_W-1:0]  RMS_MAX  = '1;
  localparam logic [zcsrm_pkg::USED_W-1:0] USED_MAX = '1;

  zcsrm_pkg::bstate_e state_q, state_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [COUNT_BITS-1:0]  n_q, n_d;
  logic                   timed_q, timed_d;
  logic [SUM_W-1:0]       quo_q [2], quo_d [2];
  logic [COUNT_BITS-1:0]  rem_q [2], rem_d [2];
  logic [X_W-1:0]         x_q [2], x_d [2];
  logic [RW-1:0]          root_q [2], root_d [2];
  logic [RW:0]            srem_q [2], srem_d [2];
  logic [P_W-1:0]         prod_q [2], prod_d [2];
  logic [zcsrm_pkg::RMS_W-1:0]  rms_q [2], rms_d [2];
  logic [zcsrm_pkg::USED_W-1:0] used_q, used_d;

  logic [COUNT_BITS:0]    dsh [2];
  logic [RW+2:0]          ssh [2], trial [2];
  logic [RND_W-1:0]       rnd [2];
  logic [zcsrm_pkg::GAIN_W-1:0] gain [2];

  assign gain[0] = cfg_i.gain_v;
  assign gain[1] = cfg_i.gain_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    timed_d = timed_q;
    used_d  = used_q;
    pop_o   = 1'b0;
    for (int l = 0; l < 2; l++) begin
      quo_d[l]  = quo_q[l];
      rem_d[l]  = rem_q[l];
      x_d[l]    = x_q[l];
      root_d[l] = root_q[l];
      srem_d[l] = srem_q[l];
      prod_d[l] = prod_q[l];
      rms_d[l]  = rms_q[l];
      dsh[l]    = {rem_q[l], quo_q[l][SUM_W-1]};
      ssh[l]    = {srem_q[l], x_q[l][X_W-1 -: 2]};
      trial[l]  = {1'b0, root_q[l], 2'b01};
      rnd[l]    = (RND_W'(prod_q[l]) + RND_W'(1 << (zcsrm_pkg::FRAC_SHIFT - 1)))
                  >> zcsrm_pkg::FRAC_SHIFT;
    end

    case (state_q)
      zcsrm_pkg::BK_IDLE: begin
        if (pop_valid_i) begin
          pop_o   = 1'b1;
          quo_d[0] = pop_data_i[SUM_W-1:0];
          quo_d[1] = pop_data_i[2*SUM_W-1:SUM_W];
          n_d      = pop_data_i[2*SUM_W +: COUNT_BITS];
          timed_d  = pop_data_i[ENTRY_W-1];
          rem_d[0] = '0;
          rem_d[1] = '0;
          cnt_d    = '0;
          state_d  = zcsrm_pkg::BK_DIV;
        end
      end
      zcsrm_pkg::BK_DIV: begin
        for (int l = 0; l < 2; l++) begin
          if (dsh[l] >= (COUNT_BITS+1)'(n_q)) begin
            rem_d[l] = COUNT_BITS'(dsh[l] - (COUNT_BITS+1)'(n_q));
            quo_d[l] = {quo_q[l][SUM_W-2:0], 1'b1};
          end else begin
            rem_d[l] = dsh[l][COUNT_BITS-1:0];
            quo_d[l] = {quo_q[l][SUM_W-2:0], 1'b0};
          end
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(SUM_W - 1)) begin
          for (int l = 0; l < 2; l++) begin
            x_d[l]    = X_W'(quo_d[l]);
            root_d[l] = '0;
            srem_d[l] = '0;
          end
          cnt_d   = '0;
          state_d = zcsrm_pkg::BK_SQRT;
        end
      end
      zcsrm_pkg::BK_SQRT: begin
        for (int l = 0; l < 2; l++) begin
          x_d[l] = x_q[l] << 2;
          if (ssh[l] >= trial[l]) begin
            srem_d[l] = (RW+1)'(ssh[l] - trial[l]);
            root_d[l] = {root_q[l][RW-2:0], 1'b1};
          end else begin
            srem_d[l] = ssh[l][RW:0];
            root_d[l] = {root_q[l][RW-2:0], 1'b0};
          end
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(RW - 1)) state_d = zcsrm_pkg::BK_MUL;
      end
      zcsrm_pkg::BK_MUL: begin
        for (int l = 0; l < 2; l++) prod_d[l] = P_W'(root_q[l]) * P_W'(gain[l]);
        state_d = zcsrm_pkg::BK_RND;
      end
      zcsrm_pkg::BK_RND: begin
        for (int l = 0; l < 2; l++) begin
          if (n_q == '0) rms_d[l] = '0;
          else if (rnd[l] > RND_W'(RMS_MAX)) rms_d[l] = RMS_MAX;
          else rms_d[l] = rnd[l][zcsrm_pkg::RMS_W-1:0];
        end
        used_d  = ((COUNT_BITS > zcsrm_pkg::USED_W) && (n_q > COUNT_BITS'(USED_MAX))) ?
                  USED_MAX : zcsrm_pkg::USED_W'(n_q);
        state_d = zcsrm_pkg::BK_OUT;
      end
      zcsrm_pkg::BK_OUT: begin
        if (!out_stall_i) state_d = zcsrm_pkg::BK_IDLE;
      end
      default: state_d = zcsrm_pkg::BK_IDLE;
    endcase
  end

  assign out_valid_o    = state_q == zcsrm_pkg::BK_OUT;
  assign v_rms_o        = rms_q[0];
  assign i_rms_o        = rms_q[1];
  assign samples_used_o = used_q;
  assign timed_out_o    = timed_q;

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    used_q <= used_d;
    for (int l = 0; l < 2; l++) begin
      quo_q[l]  <= quo_d[l];
      rem_q[l]  <= rem_d[l];
      x_q[l]    <= x_d[l];
      root_q[l] <= root_d[l];
      srem_q[l] <= srem_d[l];
      prod_q[l] <= prod_d[l];
      rms_q[l]  <= rms_d[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= zcsrm_pkg::BK_IDLE;
      cnt_q   <= '0;
      timed_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      timed_q <= timed_d;
    end
  end

  `ZC_ASSERT_IMP(a_div_cnt, state_q == zcsrm_pkg::BK_DIV, cnt_q <= CW'(SUM_W - 1), "divide step overrun")
  `ZC_ASSERT_NXT(a_pop_div, pop_o, state_q == zcsrm_pkg::BK_DIV, "pop did not start divide")
  `ZC_ASSERT_IMP(a_zero_rms, out_valid_o && samples_used_o == '0, v_rms_o == '0 && i_rms_o == '0, "rms nonzero with no samples")

endmodule

FILE: bench/tb_zero_cross_synced_rms_meter.sv
// testbench of the zero-cross synchronized rms meter: directed and random requests vs. a predictor
`timescale 1ns / 100ps

module tb_zero_cross_synced_rms_meter;

  localparam logic [1:0] OP_NONE = 2'd3;  // unused op code, ignored by the block
  localparam int CLK_HALF = 4;
  localparam int DRAIN_CYCLES = 80;       // a bit over the back end latency
  localparam int IDLE_LIMIT = 20000;      // cycles with no accepted request or result
  localparam longint SUM_TOP = (64'd1 << 34) - 1;
  localparam int PAIR_TOP = 65535;
  localparam longint RMS_TOP = 64'h1FFFFFF;

  typedef struct {
    logic [zcsrm_pkg::RMS_W-1:0]  v_rms;
    logic [zcsrm_pkg::RMS_W-1:0]  i_rms;
    logic [zcsrm_pkg::USED_W-1:0] used;
    logic                         timed_out;
  } rms_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [zcsrm_pkg::IDX_W-1:0] cfg_idx_i = '0;
  logic [zcsrm_pkg::DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] op_i = zcsrm_pkg::OP_START;
  logic [9:0] v_sample_i = '0;
  logic [9:0] i_sample_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [zcsrm_pkg::RMS_W-1:0] v_rms_o, i_rms_o;
  logic [zcsrm_pkg::USED_W-1:0] samples_used_o;
  logic timed_out_o;

  zero_cross_synced_rms_meter dut (.*);

  // predictor state
  zcsrm_pkg::cfg_t   cfg_m = zcsrm_pkg::CFG_RESET;
  zcsrm_pkg::phase_e ph_m = zcsrm_pkg::PH_IDLE;
  int unsigned ms_m, mid_m, pairs_m, cross_m;
  bit          above_m;
  longint      sq_v_m, sq_i_m;
  rms_result_t pending_q[$];

  int errors = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_timeouts = 0;
  int idle_cnt = 0;

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  function automatic longint floor_root(longint x);
    longint r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [zcsrm_pkg::RMS_W-1:0] scale_rms(longint sum, int unsigned n,
                                                            logic [zcsrm_pkg::GAIN_W-1:0] g);
    longint p;
    if (n == 0) return '0;
    p = (floor_root(sum / n) * longint'(g) + 128) >> 8;
    return (p > RMS_TOP) ? zcsrm_pkg::RMS_W'(RMS_TOP) : zcsrm_pkg::RMS_W'(p);
  endfunction

  function automatic void close_meas(bit timed);
    rms_result_t r;
    r.v_rms = scale_rms(sq_v_m, pairs_m, cfg_m.gain_v);
    r.i_rms = scale_rms(sq_i_m, pairs_m, cfg_m.gain_i);
    r.used = (pairs_m > 16'hFFFF) ? 16'hFFFF : zcsrm_pkg::USED_W'(pairs_m);
    r.timed_out = timed;
    pending_q.push_back(r);
    ph_m = zcsrm_pkg::PH_IDLE;
  endfunction

  function automatic void test_end();
    if (cross_m >= cfg_m.crossing_target) close_meas(0);
    else if (pairs_m >= PAIR_TOP) close_meas(0);
    else if (ms_m >= cfg_m.timeout_ms) close_meas(1);
  endfunction

  function automatic void open_meas();
    ph_m = zcsrm_pkg::PH_MEAS;
    ms_m = 0; pairs_m = 0; cross_m = 0; above_m = 0;
    sq_v_m = 0; sq_i_m = 0;
    test_end();
  endfunction

  function automatic void predict_request(logic [1:0] op, logic [9:0] v, logic [9:0] i);
    longint dv, di;
    bit up;
    case (op)
      zcsrm_pkg::OP_START: begin
        ph_m = zcsrm_pkg::PH_SYNC;
        ms_m = 0;
      end
      zcsrm_pkg::OP_SAMPLE: begin
        if (ph_m == zcsrm_pkg::PH_SYNC) begin
          mid_m = v;
          if (v > cfg_m.window_low && v < cfg_m.window_high) open_meas();
        end else if (ph_m == zcsrm_pkg::PH_MEAS) begin
          dv = longint'(v) - longint'(cfg_m.offset_v);
          di = longint'(i) - longint'(cfg_m.offset_i);
          up = (v > mid_m);
          pairs_m++;
          sq_v_m = (sq_v_m + dv * dv > SUM_TOP) ? SUM_TOP : sq_v_m + dv * dv;
          sq_i_m = (sq_i_m + di * di > SUM_TOP) ? SUM_TOP : sq_i_m + di * di;
          if (pairs_m > 1 && up != above_m) cross_m++;
          above_m = up;
          test_end();
        end
      end
      zcsrm_pkg::OP_TICK: begin
        if (ph_m == zcsrm_pkg::PH_SYNC) begin
          if (ms_m >= cfg_m.timeout_ms) open_meas();
          else ms_m++;
        end else if (ph_m == zcsrm_pkg::PH_MEAS) begin
          if (ms_m < 16'hFFFF) ms_m++;
          test_end();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one request, driven at the falling edge and held until accepted
  task automatic send_request(logic [1:0] op, logic [9:0] v, logic [9:0] i);
    int gap;
    op_i = op;
    v_sample_i = v;
    i_sample_i = i;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_request(op, v, i);
    n_requests++;
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // wait for every expected result, then let the back end settle
  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [zcsrm_pkg::IDX_W-1:0] idx,
                           logic [zcsrm_pkg::DATA_W-1:0] data);
    in_valid_i = 1'b0;
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      zcsrm_pkg::REG_OFFSET_V:    cfg_m.offset_v = data[9:0];
      zcsrm_pkg::REG_OFFSET_I:    cfg_m.offset_i = data[9:0];
      zcsrm_pkg::REG_WINDOW_LOW:  cfg_m.window_low = data[9:0];
      zcsrm_pkg::REG_WINDOW_HIGH: cfg_m.window_high = data[9:0];
      zcsrm_pkg::REG_CROSS_TGT:   cfg_m.crossing_target = data[9:0];
      zcsrm_pkg::REG_TIMEOUT:     cfg_m.timeout_ms = data[15:0];
      zcsrm_pkg::REG_GAIN_V:      cfg_m.gain_v = data[23:0];
      zcsrm_pkg::REG_GAIN_I:      cfg_m.gain_i = data[23:0];
      default: ;
    endcase
  endtask

  // sample value on a chosen side of the mid level
  function automatic logic [9:0] side_sample(bit up);
    if (up && mid_m < 1023) return 10'($urandom_range(mid_m + 1, 1023));
    return 10'($urandom_range(0, mid_m));
  endfunction

  task automatic test_directed();
    // requests while idle and the unused op code do nothing
    send_request(zcsrm_pkg::OP_SAMPLE, 10'd1023, 10'd1023);
    send_request(zcsrm_pkg::OP_TICK, 10'd0, 10'd0);
    send_request(OP_NONE, 10'h3FF, 10'h3FF);
    write_reg(zcsrm_pkg::REG_CROSS_TGT, 24'd3);
    write_reg(zcsrm_pkg::REG_TIMEOUT, 24'd5);
    // window bounds are exclusive
    send_request(zcsrm_pkg::OP_START, 10'd0, 10'd0);
    send_request(zcsrm_pkg::OP_SAMPLE, 10'd461, 10'd0);
    send_request(zcsrm_pkg::OP_SAMPLE, 10'd564, 10'd0);
    send_request(zcsrm_pkg::OP_SAMPLE, 10'd462, 10'd0);
    // first pair never counts a crossing
    send_request(zcsrm_pkg::OP_SAMPLE, 10'd1023, 10'd0);
    send_request(zcsrm_pkg::OP_SAMPLE, 10'd0, 10'd1023);
    send_request(zcsrm_pkg::OP_SAMPLE, 10'd1023, 10'd1023);
    send_request(zcsrm_pkg::OP_SAMPLE, 10'd0, 10'd0);
    // sync timeout, then measurement timeout with no data
    send_request(zcsrm_pkg::OP_START, 10'd0, 10'd0);
    send_request(zcsrm_pkg::OP_SAMPLE, 10'd0, 10'd0);
    repeat (12) send_request(zcsrm_pkg::OP_TICK, 10'd0, 10'd0);
    // restart drops a running measurement
    send_request(zcsrm_pkg::OP_START, 10'd0, 10'd0);
    send_request(zcsrm_pkg::OP_SAMPLE, 10'd500, 10'd3);
    send_request(zcsrm_pkg::OP_SAMPLE, 10'd700, 10'd9);
    send_request(zcsrm_pkg::OP_START, 10'd0, 10'd0);
    send_request(zcsrm_pkg::OP_SAMPLE, 10'd500, 10'd3);
    repeat (6) send_request(zcsrm_pkg::OP_TICK, 10'd0, 10'd0);
    drain();
  endtask

  task automatic random_config();
    int lo;
    lo = $urandom_range(0, 700);
    write_reg(zcsrm_pkg::REG_OFFSET_V, 24'($urandom_range(0, 1023)));
    write_reg(zcsrm_pkg::REG_OFFSET_I, 24'($urandom_range(0, 1023)));
    write_reg(zcsrm_pkg::REG_WINDOW_LOW, 24'(lo));
    write_reg(zcsrm_pkg::REG_WINDOW_HIGH, 24'($urandom_range(lo, 1023)));
    write_reg(zcsrm_pkg::REG_CROSS_TGT,
              ($urandom_range(0, 9) == 0) ? 24'd1023 : 24'($urandom_range(1, 8)));
    write_reg(zcsrm_pkg::REG_TIMEOUT, 24'($urandom_range(1, 30)));
    case ($urandom_range(0, 3))
      0: write_reg(zcsrm_pkg::REG_GAIN_V, 24'd0);
      1: write_reg(zcsrm_pkg::REG_GAIN_V, 24'hFFFFFF);
      default: write_reg(zcsrm_pkg::REG_GAIN_V, 24'($urandom));
    endcase
    case ($urandom_range(0, 3))
      0: write_reg(zcsrm_pkg::REG_GAIN_I, 24'd0);
      1: write_reg(zcsrm_pkg::REG_GAIN_I, 24'hFFFFFF);
      default: write_reg(zcsrm_pkg::REG_GAIN_I, 24'($urandom));
    endcase
  endtask

  // a start, a sync phase and a measurement with random content and noise, which a second start may cut short
  task automatic random_measurement();
    int k;
    bit up;
    send_request(zcsrm_pkg::OP_START, 10'($urandom), 10'($urandom));
    k = 0;
    while (ph_m == zcsrm_pkg::PH_SYNC && k < 40) begin
      case ($urandom_range(0, 9))
        0: send_request(OP_NONE, 10'($urandom), 10'($urandom));
        1, 2, 3: send_request(zcsrm_pkg::OP_TICK, 10'($urandom), 10'($urandom));
        default: send_request(zcsrm_pkg::OP_SAMPLE, 10'($urandom), 10'($urandom));
      endcase
      k++;
    end
    while (ph_m == zcsrm_pkg::PH_SYNC) send_request(zcsrm_pkg::OP_TICK, 10'd0, 10'd0);
    up = $urandom_range(0, 1);
    while (ph_m == zcsrm_pkg::PH_MEAS) begin
      k = $urandom_range(0, 99);
      if (k < 2) begin
        send_request(zcsrm_pkg::OP_START, 10'($urandom), 10'($urandom));
      end else if (k < 6) begin
        send_request(OP_NONE, 10'($urandom), 10'($urandom));
      end else if (k < 24) begin
        send_request(zcsrm_pkg::OP_TICK, 10'($urandom), 10'($urandom));
      end else begin
        if ($urandom_range(0, 9) < 4) up = ~up;
        send_request(zcsrm_pkg::OP_SAMPLE, side_sample(up), 10'($urandom));
      end
    end
  endtask

  task automatic test_random();
    int start_req;
    bit paused;
    start_req = n_requests;
    paused = 0;
    while (n_requests - start_req < 1000) begin
      drain();
      random_config();
      repeat ($urandom_range(2, 6)) begin
        random_measurement();
        // once, hold the sender until every result is out
        if (!paused && n_results > 10) begin
          paused = 1;
          in_valid_i = 1'b0;
          while (pending_q.size() != 0) @(negedge clk_i);
        end
      end
    end
    drain();
  endtask

  // receiver back-pressure: free stretches with short and rare long stalls
  initial begin
    int run;
    forever begin
      run = $urandom_range(0, 30);
      out_stall_i = 1'b0;
      repeat (run) @(negedge clk_i);
      run = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(20, 60);
      out_stall_i = 1'b1;
      repeat (run) @(negedge clk_i);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    rms_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $error("result with no expectation: v_rms %0d i_rms %0d", v_rms_o, i_rms_o);
        errors++;
      end else begin
        exp_r = pending_q.pop_front();
        n_results++;
        if (exp_r.timed_out) n_timeouts++;
        if (v_rms_o !== exp_r.v_rms) begin
          $error("v_rms expected %0d got %0d", exp_r.v_rms, v_rms_o);
          errors++;
        end
        if (i_rms_o !== exp_r.i_rms) begin
          $error("i_rms expected %0d got %0d", exp_r.i_rms, i_rms_o);
          errors++;
        end
        if (samples_used_o !== exp_r.used) begin
          $error("samples_used expected %0d got %0d", exp_r.used, samples_used_o);
          errors++;
        end
        if (timed_out_o !== exp_r.timed_out) begin
          $error("timed_out expected %0d got %0d", exp_r.timed_out, timed_out_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("watchdog expired, %0d results still expected", pending_q.size());
      $display("tb_zero_cross_synced_rms_meter NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random();
    if (pending_q.size() != 0) begin
      $error("%0d expected results never came", pending_q.size());
      errors++;
    end
    $display("covered %0d requests and %0d results (%0d ended by timeout)",
             n_requests, n_results, n_timeouts);
    $display("incl. window edges, sync timeout, restart, idle requests, extreme gains");
    if (errors == 0) begin
      $display("tb_zero_cross_synced_rms_meter OK");
    end else begin
      $display("tb_zero_cross_synced_rms_meter NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/zcsrm_pkg.sv
rtl/zcsrm_front.sv
rtl/zcsrm_fifo.sv
rtl/zcsrm_back.sv
rtl/zero_cross_synced_rms_meter.sv
bench/tb_zero_cross_synced_rms_meter.sv
